FILE: rtl/smlt_pkg.sv
// Package for the station MAC learning table: constants, types and helpers.
`timescale 1ns / 1ps
`default_nettype none
package smlt_pkg;

    localparam int STATION_SLOTS_DEF = 64;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int FRAMES_W = 32;
    localparam int RSSI_W  = 8;
    localparam int PROBE_W = 16;
    localparam int SLOT_OUT_W = 6;

    // 802.11 codes
    localparam logic [1:0] FTYPE_MGMT = 2'd0;
    localparam logic [1:0] FTYPE_DATA = 2'd2;
    localparam logic [3:0] FSUB_PROBE_REQ = 4'd4;

    // first-byte flag bits of a MAC
    localparam logic [7:0] MAC_GROUP_BIT = 8'h01;
    localparam logic [7:0] MAC_LOCAL_BIT = 8'h02;

    // one slot's contents
    typedef struct packed {
        logic                valid;
        logic [MAC_W-1:0]    mac;
        logic [TIME_W-1:0]   last_seen;
        logic [FRAMES_W-1:0] frames;
        logic [RSSI_W-1:0]   rssi;
        logic [PROBE_W-1:0]  probe_cnt;
        logic                random_bit;
        logic                assoc_flag;
        logic [MAC_W-1:0]    bssid;
    } smlt_entry_t;

    // the station to act on
    typedef struct packed {
        logic [MAC_W-1:0]  sta;
        logic [MAC_W-1:0]  bss;
        logic              probe;
        logic              set_bss;
        logic              ssid;
        logic [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0] now;
    } smlt_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FETCH,
        ST_WRITE,
        ST_OUT
    } smlt_state_t;

endpackage
`default_nettype wire

FILE: rtl/station_mac_learning_table.sv
// Top level of the station MAC learning table.
`timescale 1ns / 1ps
`default_nettype none
// Learns client stations from parsed 802.11 headers. Each accepted item is
// classified; for a tracked item the search record then visits the row of slot
// cells in a single pass, one slot per cycle, to find a match, the first free
// slot and the oldest slot, and the item goes on through decide, fetch and
// write to its result. An item that is not tracked gives its result in the
// cycle after accept. The block is ready again in the cycle after the result
// is taken. One item is handled at a time and every item gives exactly one
// result. No clearing pass is needed after reset.
module station_mac_learning_table
    import smlt_pkg::*;
#(
    parameter int STATION_SLOTS = STATION_SLOTS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // frame_type[1:0], frame_subtype[5:2], addr2_present[6], addr3_present[7],
    // to_distribution[8], from_distribution[9], address_one[57:10],
    // address_two[105:58], signal_dbm[113:106], now_ms[145:114],
    // ssid_present[146], zero fill to 151
    input  wire logic [151:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tracked[0], slot_index[6:1], inserted[7], evicted[8],
    // frame_count[40:9], randomized_mac[41], associated[42], zero fill to 47
    output logic [47:0]       m_tdata
);

    localparam int IDX_W = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1;
    localparam int CNT_W = $clog2(STATION_SLOTS + 1);

    // input unpack
    logic [1:0]        in_type;
    logic [3:0]        in_sub;
    logic              in_a2, in_a3, in_tds, in_fds, in_ssid;
    logic [MAC_W-1:0]  in_ad1, in_ad2;
    logic [RSSI_W-1:0] in_rssi;
    logic [TIME_W-1:0] in_now;
    assign in_type = s_tdata[1:0];
    assign in_sub  = s_tdata[5:2];
    assign in_a2   = s_tdata[6];
    assign in_a3   = s_tdata[7];
    assign in_tds  = s_tdata[8];
    assign in_fds  = s_tdata[9];
    assign in_ad1  = s_tdata[57:10];
    assign in_ad2  = s_tdata[105:58];
    assign in_rssi = s_tdata[113:106];
    assign in_now  = s_tdata[145:114];
    assign in_ssid = s_tdata[146];

    // classification of the incoming header
    logic      cls_hit;
    smlt_req_t cls_req;
    always_comb begin
        cls_hit         = 1'b0;
        cls_req.sta     = '0;
        cls_req.bss     = '0;
        cls_req.probe   = 1'b0;
        cls_req.set_bss = 1'b0;
        cls_req.ssid    = in_ssid;
        cls_req.rssi    = in_rssi;
        cls_req.now     = in_now;
        if (in_type == FTYPE_MGMT && in_sub == FSUB_PROBE_REQ && in_a2) begin
            cls_req.sta   = in_ad2;
            cls_req.probe = 1'b1;
            cls_hit       = 1'b1;
        end else if (in_type == FTYPE_DATA && in_a2) begin
            if (in_tds && !in_fds) begin
                cls_req.sta = in_ad2;
                cls_req.bss = in_ad1;
                cls_hit     = 1'b1;
            end else if (!in_tds && in_fds) begin
                cls_req.sta = in_ad1;
                cls_req.bss = in_ad2;
                cls_hit     = 1'b1;
            end
            if ((cls_req.sta[47:40] & MAC_GROUP_BIT) != 8'h00) begin
                cls_hit = 1'b0;
            end
            cls_req.set_bss = cls_hit && in_a3;
        end
    end

    smlt_state_t state_reg, state_next;
    smlt_req_t   req_reg;
    logic [CNT_W-1:0] pos_reg, pos_next;

    // running search record
    logic              r_hit_reg, r_free_reg;
    logic [IDX_W-1:0]  r_hit_idx_reg, r_free_idx_reg, r_old_idx_reg;
    logic [TIME_W-1:0] r_old_time_reg;

    logic [IDX_W-1:0]  slot_reg;
    logic              ins_reg, evi_reg;
    logic [47:0]       out_reg;
    smlt_entry_t       old_reg;

    smlt_entry_t       cell_entry [STATION_SLOTS];
    smlt_entry_t       wr_data;
    logic              c_hit   [STATION_SLOTS];
    logic              c_free  [STATION_SLOTS];
    logic [IDX_W-1:0]  c_hidx  [STATION_SLOTS];
    logic [IDX_W-1:0]  c_fidx  [STATION_SLOTS];
    logic [IDX_W-1:0]  c_oidx  [STATION_SLOTS];
    logic [TIME_W-1:0] c_otime [STATION_SLOTS];

    logic              scanning;
    assign scanning = (state_reg == ST_SCAN);

    // row of cells; the addressed cell folds its slot into the record
    for (genvar g = 0; g < STATION_SLOTS; g++) begin : g_cell
        smlt_cell #(.IDX_W(IDX_W)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .scan_en     (scanning && pos_reg[IDX_W-1:0] == IDX_W'(g)),
            .key         (req_reg.sta),
            .my_index    (IDX_W'(g)),
            .hit_in      (r_hit_reg),
            .free_in     (r_free_reg),
            .hit_idx_in  (r_hit_idx_reg),
            .free_idx_in (r_free_idx_reg),
            .old_idx_in  (r_old_idx_reg),
            .old_time_in (r_old_time_reg),
            .hit_out     (c_hit[g]),
            .free_out    (c_free[g]),
            .hit_idx_out (c_hidx[g]),
            .free_idx_out(c_fidx[g]),
            .old_idx_out (c_oidx[g]),
            .old_time_out(c_otime[g]),
            .wr_en       (state_reg == ST_WRITE && slot_reg == IDX_W'(g)),
            .wr_data     (wr_data),
            .entry       (cell_entry[g])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                pos_next = '0;
                if (s_tvalid) begin
                    state_next = cls_hit ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == CNT_W'(STATION_SLOTS - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = out_reg;
    end

    // updated entry for the chosen slot
    smlt_entry_t base;
    always_comb begin
        base = old_reg;
        if (ins_reg) begin
            base.valid       = 1'b1;
            base.mac         = req_reg.sta;
            base.frames      = '0;
            base.probe_cnt   = '0;
            base.random_bit  = (req_reg.sta[47:40] & MAC_LOCAL_BIT) != 8'h00;
            base.assoc_flag  = 1'b0;
            base.bssid       = '0;
        end
        wr_data           = base;
        wr_data.rssi      = req_reg.rssi;
        wr_data.frames    = base.frames + 1'b1;
        wr_data.last_seen = req_reg.now;
        if (req_reg.probe && req_reg.ssid) begin
            wr_data.probe_cnt = base.probe_cnt + 1'b1;
        end
        if (req_reg.set_bss) begin
            wr_data.bssid      = req_reg.bss;
            wr_data.assoc_flag = 1'b1;
        end
    end

    logic [IDX_W-1:0] cur;
    assign cur = pos_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg        <= cls_req;
                r_hit_reg      <= 1'b0;
                r_free_reg     <= 1'b0;
                r_hit_idx_reg  <= '0;
                r_free_idx_reg <= '0;
                r_old_idx_reg  <= '0;
                r_old_time_reg <= '0;
                out_reg        <= '0;
            end
            ST_SCAN: begin
                r_hit_reg      <= c_hit[cur];
                r_free_reg     <= c_free[cur];
                r_hit_idx_reg  <= c_hidx[cur];
                r_free_idx_reg <= c_fidx[cur];
                r_old_idx_reg  <= c_oidx[cur];
                r_old_time_reg <= c_otime[cur];
            end
            ST_DECIDE: begin
                if (r_hit_reg) begin
                    slot_reg <= r_hit_idx_reg;
                    ins_reg  <= 1'b0;
                    evi_reg  <= 1'b0;
                end else if (r_free_reg) begin
                    slot_reg <= r_free_idx_reg;
                    ins_reg  <= 1'b1;
                    evi_reg  <= 1'b0;
                end else begin
                    slot_reg <= r_old_idx_reg;
                    ins_reg  <= 1'b1;
                    evi_reg  <= 1'b1;
                end
            end
            ST_FETCH: begin
                old_reg <= cell_entry[slot_reg];
            end
            ST_WRITE: begin
                out_reg <= {5'd0, wr_data.assoc_flag, wr_data.random_bit,
                            wr_data.frames, evi_reg, ins_reg,
                            SLOT_OUT_W'(32'(slot_reg)), 1'b1};
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/smlt_cell.sv
// One table slot: holds an entry and passes the running search record on.
`timescale 1ns / 1ps
`default_nettype none
module smlt_cell
    import smlt_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // this cell sees the token and compares during this cycle
    input  wire logic             scan_en,
    input  wire logic [MAC_W-1:0] key,
    input  wire logic [IDX_W-1:0] my_index,
    // search record in
    input  wire logic             hit_in,
    input  wire logic             free_in,
    input  wire logic [IDX_W-1:0] hit_idx_in,
    input  wire logic [IDX_W-1:0] free_idx_in,
    input  wire logic [IDX_W-1:0] old_idx_in,
    input  wire logic [TIME_W-1:0] old_time_in,
    // search record out
    output logic                  hit_out,
    output logic                  free_out,
    output logic [IDX_W-1:0]      hit_idx_out,
    output logic [IDX_W-1:0]      free_idx_out,
    output logic [IDX_W-1:0]      old_idx_out,
    output logic [TIME_W-1:0]     old_time_out,
    // write port
    input  wire logic             wr_en,
    input  wire smlt_entry_t      wr_data,
    output smlt_entry_t           entry
);

    smlt_entry_t entry_reg;
    logic        first;

    assign entry = entry_reg;
    assign first = (my_index == '0);

    // fold this slot into the search record
    always_comb begin
        hit_out      = hit_in;
        hit_idx_out  = hit_idx_in;
        free_out     = free_in;
        free_idx_out = free_idx_in;
        old_idx_out  = old_idx_in;
        old_time_out = old_time_in;
        if (scan_en) begin
            if (!hit_in && entry_reg.valid && entry_reg.mac == key) begin
                hit_out     = 1'b1;
                hit_idx_out = my_index;
            end
            if (!free_in && !entry_reg.valid) begin
                free_out     = 1'b1;
                free_idx_out = my_index;
            end
            if (first || entry_reg.last_seen < old_time_in) begin
                old_idx_out  = my_index;
                old_time_out = entry_reg.last_seen;
            end
        end
    end

    // storage; only the valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else if (wr_en) begin
            entry_reg <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for the station MAC learning table: random and directed frames, scoreboard check.
`timescale 1ns / 1ps
module tb;
    import smlt_pkg::*;

    localparam int SLOTS = 64;

    // lowest tdata bit last
    typedef struct packed {
        logic        associated;
        logic        randomized_mac;
        logic [31:0] frame_count;
        logic        evicted;
        logic        inserted;
        logic [5:0]  slot_index;
        logic        tracked;
    } station_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    station_mac_learning_table i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor copy of the station table
    logic        sta_valid [SLOTS];
    logic [47:0] sta_mac [SLOTS];
    logic [31:0] sta_seen [SLOTS];
    logic [31:0] sta_frames [SLOTS];
    logic        sta_local [SLOTS];
    logic        sta_assoc [SLOTS];

    logic [151:0]    frame_queue [$];
    station_result_t expected_results [$];
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_sender = 1'b0;
    logic [47:0] known_macs [$];

    // model one accepted frame header
    function automatic station_result_t learn_frame(logic [151:0] d);
        station_result_t r;
        logic [1:0]  ftype;
        logic [3:0]  fsub;
        logic        a2, a3, tds, fds, probe, hit, set_bss;
        logic [47:0] ad1, ad2, sta, bss;
        logic [31:0] now;
        int          slot;
        bit          found;
        r = '0;
        ftype = d[1:0];
        fsub = d[5:2];
        a2 = d[6];
        a3 = d[7];
        tds = d[8];
        fds = d[9];
        ad1 = d[57:10];
        ad2 = d[105:58];
        now = d[145:114];
        probe = 1'b0;
        hit = 1'b0;
        sta = '0;
        bss = '0;
        if (ftype == FTYPE_MGMT && fsub == FSUB_PROBE_REQ && a2) begin
            sta = ad2;
            probe = 1'b1;
            hit = 1'b1;
        end else if (ftype == FTYPE_DATA && a2) begin
            if (tds && !fds) begin
                sta = ad2;
                bss = ad1;
                hit = 1'b1;
            end else if (!tds && fds) begin
                sta = ad1;
                bss = ad2;
                hit = 1'b1;
            end
            if (hit && (sta[47:40] & MAC_GROUP_BIT) != 0) hit = 1'b0;
        end
        set_bss = hit && !probe && a3;
        if (!hit) return r;
        found = 1'b0;
        slot = 0;
        for (int i = 0; i < SLOTS; i++)
            if (!found && sta_valid[i] && sta_mac[i] == sta) begin
                slot = i;
                found = 1'b1;
            end
        if (!found) begin
            r.inserted = 1'b1;
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !sta_valid[i]) slot = i;
            if (slot < 0) begin
                r.evicted = 1'b1;
                slot = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (sta_seen[i] < sta_seen[slot]) slot = i;
            end
            sta_valid[slot] = 1'b1;
            sta_mac[slot] = sta;
            sta_frames[slot] = '0;
            sta_local[slot] = (sta[47:40] & MAC_LOCAL_BIT) != 0;
            sta_assoc[slot] = 1'b0;
        end
        sta_frames[slot] = sta_frames[slot] + 1;
        sta_seen[slot] = now;
        if (set_bss) sta_assoc[slot] = 1'b1;
        r.tracked = 1'b1;
        r.slot_index = slot[5:0];
        r.frame_count = sta_frames[slot];
        r.randomized_mac = sta_local[slot];
        r.associated = sta_assoc[slot];
        return r;
    endfunction

    function automatic logic [151:0] pack_frame(logic [1:0] ft, logic [3:0] fs, logic a2,
            logic a3, logic tds, logic fds, logic [47:0] ad1, logic [47:0] ad2,
            logic [7:0] dbm, logic [31:0] now, logic ssid);
        return {5'd0, ssid, now, dbm, ad2, ad1, fds, tds, a3, a2, fs, ft};
    endfunction

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom, $urandom});
    endfunction

    // station address: mostly reused, unicast, sometimes fresh or group
    function automatic logic [47:0] pick_station();
        logic [47:0] m;
        if (known_macs.size() > 0 && $urandom_range(0, 99) < 60)
            return known_macs[$urandom_range(0, known_macs.size() - 1)];
        m = rand_mac();
        if ($urandom_range(0, 9) != 0) m[40] = 1'b0;
        if (known_macs.size() < 90) known_macs.push_back(m);
        return m;
    endfunction

    function automatic logic [151:0] random_frame();
        logic [47:0] sta, oth;
        logic [1:0]  ft;
        logic [3:0]  fs;
        logic        tds, fds;
        int          kind;
        sta = pick_station();
        oth = rand_mac();
        kind = $urandom_range(0, 9);
        tds = 1'($urandom);
        fds = 1'($urandom);
        ft = FTYPE_DATA;
        fs = 4'($urandom);
        if (kind < 4) begin
            ft = FTYPE_MGMT;
            fs = FSUB_PROBE_REQ;
        end else if (kind < 8) begin
            tds = kind[0];
            fds = !kind[0];
        end else begin
            ft = 2'($urandom);
        end
        // to-DS: station in addr2; from-DS: station in addr1
        if (ft == FTYPE_DATA && !tds && fds)
            return pack_frame(ft, fs, $urandom_range(0, 19) != 0, 1'($urandom), tds, fds,
                sta, oth, 8'($urandom), $urandom, 1'($urandom));
        return pack_frame(ft, fs, $urandom_range(0, 19) != 0, 1'($urandom), tds, fds,
            oth, sta, 8'($urandom), $urandom, 1'($urandom));
    endfunction

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (frame_queue.size() > 0 && !hold_sender &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= frame_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on input accept
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(learn_frame(s_tdata));
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        station_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[42:0];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // stimulus
    initial begin
        logic [47:0] a, b;
        for (int i = 0; i < SLOTS; i++) begin
            sta_valid[i] = 1'b0;
            sta_seen[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        a = 48'h02_11_22_33_44_55;
        b = 48'h00_AA_BB_CC_DD_EE;
        // directed: probe, data to/from DS, group address, bad DS combos, extremes
        frame_queue.push_back(pack_frame(FTYPE_MGMT, FSUB_PROBE_REQ, 1, 0, 0, 0, '0, a,
            8'h80, 32'hFFFF_FFFF, 1));
        frame_queue.push_back(pack_frame(FTYPE_MGMT, FSUB_PROBE_REQ, 1, 1, 1, 1, '1, a,
            8'h7F, 32'd0, 0));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 1, 1, 1, 0, b, a, 8'h00, 5, 0));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'hF, 1, 1, 0, 1, b, a, 8'hC0, 6, 1));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 1, 0, 0, 1, b, a, 8'hC0, 7, 1));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 1, 1, 1, 0, a, '1, 8'h01, 8, 0));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 1, 1, 0, 1, 48'h01_00_5E_00_00_01,
            b, 8'h01, 9, 0));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 1, 1, 0, 0, b, a, 8'h01, 10, 0));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 1, 1, 1, 1, b, a, 8'h01, 11, 0));
        frame_queue.push_back(pack_frame(FTYPE_DATA, 4'd0, 0, 1, 1, 0, b, a, 8'h01, 12, 0));
        frame_queue.push_back(pack_frame(FTYPE_MGMT, FSUB_PROBE_REQ, 0, 1, 0, 0, b, a, 1, 13, 1));
        frame_queue.push_back(pack_frame(FTYPE_MGMT, 4'd5, 1, 1, 0, 0, b, a, 1, 14, 1));
        frame_queue.push_back(pack_frame(2'd1, FSUB_PROBE_REQ, 1, 1, 0, 0, b, a, 1, 15, 1));
        frame_queue.push_back(pack_frame(2'd3, 4'd0, 1, 1, 1, 0, b, a, 1, 16, 1));
        frame_queue.push_back(pack_frame(FTYPE_MGMT, FSUB_PROBE_REQ, 1, 0, 0, 0, '0, '0,
            0, 17, 1));
        // fill the table and force evictions, including ties on last-seen
        for (int i = 0; i < 70; i++)
            frame_queue.push_back(pack_frame(FTYPE_MGMT, FSUB_PROBE_REQ, 1, 0, 0, 0, '0,
                {16'h0200, 32'(i)} ^ {1'($urandom_range(0, 1)), 47'd0}, 0,
                (i % 3 == 0) ? 32'd100 : 32'(1000 + i), 1));
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int k = 0; k < 165; k++) frame_queue.push_back(random_frame());
            while (frame_queue.size() > 0) @(posedge aclk);
            // pause until the block drains
            hold_sender = 1'b1;
            while (expected_results.size() > 0 || s_tvalid) @(posedge aclk);
            hold_sender = 1'b0;
        end
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

FILE: files.f
rtl/smlt_pkg.sv
rtl/smlt_cell.sv
rtl/station_mac_learning_table.sv
sim/tb.sv
